/* hdl/wpsp_pkg.sv */
// Package with the shared types and constants of the WAV PCM stream parser.
package wpsp_pkg;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_EOF  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_DONE   = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_NOT_RIFF = 3'd1,
    ERR_NOT_WAVE = 3'd2,
    ERR_FORMAT   = 3'd3,
    ERR_NO_DATA  = 3'd4
  } err_t;

  localparam logic [31:0] TAG_RIFF    = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE    = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT     = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA    = 32'h6461_7461;
  localparam logic [31:0] FMT_MIN_LEN = 32'd16;

  typedef struct packed {
    op_t        op;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [15:0] sample;
    logic [31:0]        sample_rate;
    err_t               error_code;
    logic               last;
  } out_item_t;

endpackage

/* hdl/wpsp_if.sv */
// Valid/ready channel interfaces for the byte input and the result output.
interface wpsp_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] data_byte;

  modport source (output valid, output op, output data_byte, input ready);
  modport sink   (input valid, input op, input data_byte, output ready);
endinterface

interface wpsp_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [15:0] sample;
  logic [31:0]        sample_rate;
  logic [2:0]         error_code;
  logic               last;

  modport source (output valid, output kind, output sample, output sample_rate,
                  output error_code, output last, input ready);
  modport sink   (input valid, input kind, input sample, input sample_rate,
                  input error_code, input last, output ready);
endinterface

/* hdl/wav_pcm_stream_parser_top.sv */
// Top level of the WAV PCM stream parser: input register, parser and result register.
//
// The in_ch channel takes one request per cycle: op selects a file byte in
// data_byte or the end-of-file marker. The out_ch channel returns mono 16-bit
// samples, then one final status (completion with the sample rate, or an error
// code) flagged by last.
// An accepted byte waits in the input register until the parser takes it, and
// its result, if any, waits in the result register for the receiver. Throughput
// is one byte per cycle while the receiver does not stall; every byte is handled
// by a single pass of the step logic between the input and result registers.
// After reset the parser expects a RIFF tag and both registers are empty. The
// end-of-file marker always returns the parser to that state.
// When the receiver stalls with a result waiting, the parser holds, the input
// register keeps its byte and in_ch.ready drops once that register is full.
module wav_pcm_stream_parser_top (
  input  logic       clk,
  input  logic       rst_n,
  wpsp_in_if.sink    in_ch,
  wpsp_out_if.source out_ch
);
  import wpsp_pkg::*;

  logic      item_valid;
  in_item_t  item;
  logic      out_free;
  logic      fire;
  logic      res_valid;
  out_item_t res;

  assign fire = item_valid && out_free;

  wpsp_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .fire       (fire),
    .item_valid (item_valid),
    .item       (item)
  );

  wpsp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  wpsp_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_ch    (out_ch),
    .res_valid (res_valid),
    .res       (res),
    .fire      (fire),
    .out_free  (out_free)
  );
endmodule

/* hdl/wpsp_in_stage.sv */
// Input register that holds one accepted request until the parser consumes it.
module wpsp_in_stage (
  input  logic                clk,
  input  logic                rst_n,
  wpsp_in_if.sink             in_ch,
  input  logic                fire,
  output logic                item_valid,
  output wpsp_pkg::in_item_t  item
);
  import wpsp_pkg::*;

  logic     in_v_r;
  in_item_t item_r;

  assign in_ch.ready = !in_v_r || fire;
  assign item_valid  = in_v_r;
  assign item        = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
    if (in_ch.valid && in_ch.ready) begin
      item_r.op        <= op_t'(in_ch.op);
      item_r.data_byte <= in_ch.data_byte;
    end
  end
endmodule

/* hdl/wpsp_parser.sv */
// Parser state and the per-byte step logic for RIFF/WAVE headers and PCM data.
module wpsp_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  wpsp_pkg::in_item_t  item,
  output logic                res_valid,
  output wpsp_pkg::out_item_t res
);
  import wpsp_pkg::*;

  typedef enum logic [2:0] {
    PH_RIFF, PH_SIZE, PH_WAVE, PH_HDR, PH_FMT, PH_SKIP, PH_DATA, PH_PEND
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [4:0]  bc_r, bc_nxt;
  logic [31:0] tag_r, tag_nxt;
  logic [31:0] len_r, len_nxt;
  logic [15:0] chan_r, chan_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [7:0]  low_r, low_nxt;
  logic        fmt_seen_r, fmt_seen_nxt;
  logic        reported_r, reported_nxt;
  logic        pad_r, pad_nxt;
  logic [7:0]  b;
  logic [31:0] skip_len;

  assign b = item.data_byte;

  always_comb begin
    phase_nxt    = phase_r;
    bc_nxt       = bc_r;
    tag_nxt      = tag_r;
    len_nxt      = len_r;
    chan_nxt     = chan_r;
    rate_nxt     = rate_r;
    low_nxt      = low_r;
    fmt_seen_nxt = fmt_seen_r;
    reported_nxt = reported_r;
    pad_nxt      = pad_r;
    res_valid    = 1'b0;
    res          = '0;
    skip_len     = len_r - FMT_MIN_LEN;

    if (item.op == OP_EOF) begin
      if (!reported_r) begin
        res_valid = 1'b1;
        res.last  = 1'b1;
        case (phase_r)
          PH_RIFF: begin
            res.kind       = KIND_ERROR;
            res.error_code = ERR_NOT_RIFF;
          end
          PH_SIZE, PH_WAVE: begin
            res.kind       = KIND_ERROR;
            res.error_code = ERR_NOT_WAVE;
          end
          PH_DATA, PH_PEND: begin
            res.kind        = KIND_DONE;
            res.sample_rate = rate_r;
          end
          default: begin
            res.kind       = KIND_ERROR;
            res.error_code = ERR_NO_DATA;
          end
        endcase
      end
      // The end marker always starts a fresh file.
      phase_nxt    = PH_RIFF;
      bc_nxt       = '0;
      tag_nxt      = '0;
      len_nxt      = '0;
      chan_nxt     = '0;
      rate_nxt     = '0;
      low_nxt      = '0;
      fmt_seen_nxt = 1'b0;
      reported_nxt = 1'b0;
      pad_nxt      = 1'b0;
    end else if (!reported_r) begin
      case (phase_r)
        PH_RIFF, PH_WAVE: begin
          tag_nxt = {tag_r[23:0], b};
          if (bc_r == 5'd3) begin
            bc_nxt = '0;
            if (phase_r == PH_RIFF) begin
              if (tag_nxt != TAG_RIFF) begin
                res_valid      = 1'b1;
                res.kind       = KIND_ERROR;
                res.error_code = ERR_NOT_RIFF;
                res.last       = 1'b1;
                reported_nxt   = 1'b1;
              end else begin
                phase_nxt = PH_SIZE;
              end
            end else begin
              if (tag_nxt != TAG_WAVE) begin
                res_valid      = 1'b1;
                res.kind       = KIND_ERROR;
                res.error_code = ERR_NOT_WAVE;
                res.last       = 1'b1;
                reported_nxt   = 1'b1;
              end else begin
                phase_nxt = PH_HDR;
              end
            end
          end else begin
            bc_nxt = bc_r + 5'd1;
          end
        end
        PH_SIZE: begin
          if (bc_r == 5'd3) begin
            bc_nxt    = '0;
            phase_nxt = PH_WAVE;
          end else begin
            bc_nxt = bc_r + 5'd1;
          end
        end
        PH_HDR: begin
          if (bc_r < 5'd4) begin
            tag_nxt = {tag_r[23:0], b};
            if (bc_r == 5'd3) begin
              len_nxt = '0;
            end
          end else begin
            case (bc_r[1:0])
              2'd0:    len_nxt[7:0]   = len_r[7:0]   | b;
              2'd1:    len_nxt[15:8]  = len_r[15:8]  | b;
              2'd2:    len_nxt[23:16] = len_r[23:16] | b;
              default: len_nxt[31:24] = len_r[31:24] | b;
            endcase
          end
          bc_nxt = bc_r + 5'd1;
          if (bc_r == 5'd7) begin
            if (tag_r == TAG_FMT && len_nxt >= FMT_MIN_LEN) begin
              phase_nxt = PH_FMT;
              bc_nxt    = '0;
            end else if (tag_r == TAG_DATA) begin
              if (!fmt_seen_r || chan_r != 16'd1 || rate_r == 32'd0) begin
                res_valid      = 1'b1;
                res.kind       = KIND_ERROR;
                res.error_code = ERR_FORMAT;
                res.last       = 1'b1;
                reported_nxt   = 1'b1;
              end else if (len_nxt == 32'd0) begin
                res_valid       = 1'b1;
                res.kind        = KIND_DONE;
                res.sample_rate = rate_r;
                res.last        = 1'b1;
                reported_nxt    = 1'b1;
              end else begin
                phase_nxt = PH_DATA;
                bc_nxt    = '0;
              end
            end else begin
              // Unknown or short chunk: skip its body and any pad byte.
              pad_nxt = len_nxt[0];
              if (len_nxt == 32'd0) begin
                phase_nxt = PH_HDR;
                bc_nxt    = '0;
              end else begin
                phase_nxt = PH_SKIP;
              end
            end
          end
        end
        PH_FMT: begin
          case (bc_r)
            5'd2:    chan_nxt = {8'd0, b};
            5'd3:    chan_nxt = {b, chan_r[7:0]};
            5'd4:    rate_nxt = {24'd0, b};
            5'd5:    rate_nxt[15:8]  = b;
            5'd6:    rate_nxt[23:16] = b;
            5'd7:    rate_nxt[31:24] = b;
            default: ;
          endcase
          bc_nxt = bc_r + 5'd1;
          if (bc_r == 5'd15) begin
            fmt_seen_nxt = 1'b1;
            len_nxt      = skip_len;
            pad_nxt      = len_r[0];
            if (skip_len == 32'd0 && !len_r[0]) begin
              phase_nxt = PH_HDR;
              bc_nxt    = '0;
            end else begin
              phase_nxt = PH_SKIP;
            end
          end
        end
        PH_SKIP: begin
          if (len_r != 32'd0) begin
            len_nxt = len_r - 32'd1;
          end else begin
            pad_nxt = 1'b0;
          end
          if (len_nxt == 32'd0 && !pad_nxt) begin
            phase_nxt = PH_HDR;
            bc_nxt    = '0;
          end
        end
        PH_DATA: begin
          bc_nxt  = bc_r + 5'd1;
          len_nxt = len_r - 32'd1;
          if (bc_r[0]) begin
            res_valid  = 1'b1;
            res.kind   = KIND_SAMPLE;
            res.sample = {b, low_r};
          end else begin
            low_nxt = b;
          end
          if (len_nxt == 32'd0) begin
            if (bc_r[0]) begin
              phase_nxt = PH_PEND;
            end else begin
              res_valid       = 1'b1;
              res.kind        = KIND_DONE;
              res.sample_rate = rate_r;
              res.last        = 1'b1;
              reported_nxt    = 1'b1;
            end
          end
        end
        PH_PEND: begin
          res_valid       = 1'b1;
          res.kind        = KIND_DONE;
          res.sample_rate = rate_r;
          res.last        = 1'b1;
          reported_nxt    = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_RIFF;
      bc_r       <= '0;
      tag_r      <= '0;
      len_r      <= '0;
      chan_r     <= '0;
      rate_r     <= '0;
      low_r      <= '0;
      fmt_seen_r <= 1'b0;
      reported_r <= 1'b0;
      pad_r      <= 1'b0;
    end else if (fire) begin
      phase_r    <= phase_nxt;
      bc_r       <= bc_nxt;
      tag_r      <= tag_nxt;
      len_r      <= len_nxt;
      chan_r     <= chan_nxt;
      rate_r     <= rate_nxt;
      low_r      <= low_nxt;
      fmt_seen_r <= fmt_seen_nxt;
      reported_r <= reported_nxt;
      pad_r      <= pad_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // Once a status has gone out, file bytes produce nothing until the end marker.
  a_quiet_after_status: assert property (@(posedge clk) disable iff (!rst_n)
    fire && reported_r && item.op == OP_BYTE |-> !res_valid)
    else $error("result produced after status was reported");

  // The end marker returns the parser to its start state.
  a_eof_resets: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.op == OP_EOF |=> phase_r == PH_RIFF && !reported_r && !fmt_seen_r)
    else $error("end marker did not reset the parser");

  // A status result from a file byte leaves the parser in the reported state.
  a_status_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res_valid && res.last && item.op == OP_BYTE |=> reported_r)
    else $error("status result without reported flag");

  // Samples come only from the data chunk body.
  a_sample_in_data: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res_valid && res.kind == KIND_SAMPLE |-> phase_r == PH_DATA && bc_r[0])
    else $error("sample produced outside the data body");
`endif
endmodule

/* hdl/wpsp_out_stage.sv */
// Result register that holds one result until the receiver takes it.
module wpsp_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  wpsp_out_if.source          out_ch,
  input  logic                res_valid,
  input  wpsp_pkg::out_item_t res,
  input  logic                fire,
  output logic                out_free
);
  import wpsp_pkg::*;

  logic      out_v_r;
  out_item_t res_r;

  assign out_free           = !out_v_r || out_ch.ready;
  assign out_ch.valid       = out_v_r;
  assign out_ch.kind        = res_r.kind;
  assign out_ch.sample      = res_r.sample;
  assign out_ch.sample_rate = res_r.sample_rate;
  assign out_ch.error_code  = res_r.error_code;
  assign out_ch.last        = res_r.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (fire && res_valid) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
    if (fire && res_valid) begin
      res_r <= res;
    end
  end
endmodule

/* tb/wav_pcm_stream_parser_top_test.sv */
// Self-checking testbench for the WAV PCM stream parser with random RIFF/WAVE files.
module wav_pcm_stream_parser_top_test;
  import wpsp_pkg::*;

  typedef enum logic [2:0] {
    PH_RIFF,
    PH_SIZE,
    PH_WAVE,
    PH_HDR,
    PH_FMT,
    PH_SKIP,
    PH_DATA,
    PH_PEND
  } parse_phase_t;

  // Tracks the parse of the byte stream and holds the results it predicts.
  class pcm_stream_tracker;
    parse_phase_t phase_now;
    logic [31:0]  field_pos;
    logic [31:0]  tag_bits;
    logic [31:0]  chunk_left;
    logic [31:0]  rate_hz;
    logic [15:0]  channels;
    logic [7:0]   low_hold;
    bit           fmt_read;
    bit           status_sent;
    bit           pad_owed;
    out_item_t    awaited_results[$];
    int           mismatch_count;

    function new();
      mismatch_count = 0;
      clear_state();
    endfunction

    function void clear_state();
      phase_now   = PH_RIFF;
      field_pos   = '0;
      tag_bits    = '0;
      chunk_left  = '0;
      rate_hz     = '0;
      channels    = '0;
      low_hold    = '0;
      fmt_read    = 1'b0;
      status_sent = 1'b0;
      pad_owed    = 1'b0;
    endfunction

    function void add_result(kind_t k, logic [15:0] smp, logic [31:0] rate, err_t code,
                             logic fin);
      out_item_t r;
      r.kind        = k;
      r.sample      = smp;
      r.sample_rate = rate;
      r.error_code  = code;
      r.last        = fin;
      awaited_results.push_back(r);
    endfunction

    function void give_error(err_t code);
      status_sent = 1'b1;
      add_result(KIND_ERROR, 16'd0, 32'd0, code, 1'b1);
    endfunction

    function void give_done();
      status_sent = 1'b1;
      add_result(KIND_DONE, 16'd0, rate_hz, ERR_NONE, 1'b1);
    endfunction

    function void begin_skip(logic [31:0] count, bit pad);
      chunk_left = count;
      pad_owed   = pad;
      if (count == 0 && !pad) begin
        phase_now = PH_HDR;
        field_pos = '0;
      end else begin
        phase_now = PH_SKIP;
      end
    endfunction

    function void close_header();
      if (tag_bits == TAG_FMT && chunk_left >= FMT_MIN_LEN) begin
        phase_now = PH_FMT;
        field_pos = '0;
      end else if (tag_bits == TAG_DATA) begin
        if (!fmt_read || channels != 16'd1 || rate_hz == 0) begin
          give_error(ERR_FORMAT);
        end else if (chunk_left == 0) begin
          give_done();
        end else begin
          phase_now = PH_DATA;
          field_pos = '0;
        end
      end else begin
        begin_skip(chunk_left, chunk_left[0]);
      end
    endfunction

    // Returns 0 for a byte that the parser ignores because its status is out.
    function bit take_request(op_t op, logic [7:0] b);
      bit second;
      if (op == OP_EOF) begin
        if (!status_sent) begin
          case (phase_now)
            PH_RIFF:          give_error(ERR_NOT_RIFF);
            PH_SIZE, PH_WAVE: give_error(ERR_NOT_WAVE);
            PH_DATA, PH_PEND: give_done();
            default:          give_error(ERR_NO_DATA);
          endcase
        end
        clear_state();
        return 1'b1;
      end
      if (status_sent) return 1'b0;
      case (phase_now)
        PH_RIFF, PH_WAVE: begin
          tag_bits = {tag_bits[23:0], b};
          field_pos++;
          if (field_pos >= 4) begin
            field_pos = '0;
            if (phase_now == PH_RIFF) begin
              if (tag_bits != TAG_RIFF) give_error(ERR_NOT_RIFF);
              else phase_now = PH_SIZE;
            end else if (tag_bits != TAG_WAVE) begin
              give_error(ERR_NOT_WAVE);
            end else begin
              phase_now = PH_HDR;
            end
          end
        end
        PH_SIZE: begin
          field_pos++;
          if (field_pos >= 4) begin
            field_pos = '0;
            phase_now = PH_WAVE;
          end
        end
        PH_HDR: begin
          if (field_pos < 4) begin
            tag_bits = {tag_bits[23:0], b};
            if (field_pos == 3) chunk_left = '0;
          end else begin
            chunk_left = chunk_left | (32'(b) << (8 * field_pos[1:0]));
          end
          field_pos++;
          if (field_pos >= 8) close_header();
        end
        PH_FMT: begin
          if (field_pos == 2) begin
            channels = {8'd0, b};
          end else if (field_pos == 3) begin
            channels[15:8] = b;
          end else if (field_pos >= 4 && field_pos <= 7) begin
            if (field_pos == 4) rate_hz = '0;
            rate_hz = rate_hz | (32'(b) << (8 * field_pos[1:0]));
          end
          field_pos++;
          if (field_pos >= FMT_MIN_LEN) begin
            fmt_read = 1'b1;
            begin_skip(chunk_left - FMT_MIN_LEN, chunk_left[0]);
          end
        end
        PH_SKIP: begin
          if (chunk_left > 0) chunk_left--;
          else pad_owed = 1'b0;
          if (chunk_left == 0 && !pad_owed) begin
            phase_now = PH_HDR;
            field_pos = '0;
          end
        end
        PH_DATA: begin
          second = field_pos[0];
          field_pos++;
          chunk_left--;
          if (second) add_result(KIND_SAMPLE, {b, low_hold}, 32'd0, ERR_NONE, 1'b0);
          else low_hold = b;
          // A body ending on a sample reports completion on the next request.
          if (chunk_left == 0) begin
            if (second) phase_now = PH_PEND;
            else give_done();
          end
        end
        PH_PEND: give_done();
        default: ;
      endcase
      return 1'b1;
    endfunction

    function void report(string label, out_item_t want, out_item_t got);
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t %s: expected kind %0d sample %0d rate %0d err %0d last %0d",
                 $realtime, label, want.kind, want.sample, want.sample_rate,
                 want.error_code, want.last,
                 "; got kind %0d sample %0d rate %0d err %0d last %0d",
                 got.kind, got.sample, got.sample_rate, got.error_code, got.last);
    endfunction

    function void compare_result(out_item_t got);
      out_item_t want;
      if (awaited_results.size() == 0) begin
        want = '0;
        report("result with nothing awaited", want, got);
        return;
      end
      want = awaited_results.pop_front();
      if (got.kind !== want.kind || got.sample !== want.sample ||
          got.sample_rate !== want.sample_rate || got.error_code !== want.error_code ||
          got.last !== want.last)
        report("result mismatch", want, got);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  wpsp_in_if  in_ch();
  wpsp_out_if out_ch();

  wav_pcm_stream_parser_top uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  pcm_stream_tracker tracker = new();
  logic [7:0] file_bytes[$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_request = 0;
  int accepted_items = 0;

  always #5 clk = ~clk;

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  initial begin
    out_item_t got;
    int hold_left;
    int hold_served;
    hold_left = 0;
    hold_served = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.kind        = kind_t'(out_ch.kind);
        got.sample      = out_ch.sample;
        got.sample_rate = out_ch.sample_rate;
        got.error_code  = err_t'(out_ch.error_code);
        got.last        = out_ch.last;
        tracker.compare_result(got);
      end
      if (hold_request != hold_served) begin
        hold_served = hold_request;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_item(op_t op, logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.op        <= op;
    in_ch.data_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    if (tracker.take_request(op, b)) accepted_items++;
  endtask

  task automatic send_file();
    foreach (file_bytes[i]) send_item(OP_BYTE, file_bytes[i]);
    send_item(OP_EOF, 8'($urandom));
  endtask

  task automatic wait_results_drained(int limit);
    int waited;
    waited = 0;
    in_ch.valid <= 1'b0;
    while (tracker.awaited_results.size() != 0 && waited < limit) begin
      @(posedge clk);
      waited++;
    end
    repeat (6) @(posedge clk);
  endtask

  function automatic void put_word_be(logic [31:0] w);
    file_bytes.push_back(w[31:24]);
    file_bytes.push_back(w[23:16]);
    file_bytes.push_back(w[15:8]);
    file_bytes.push_back(w[7:0]);
  endfunction

  function automatic void put_word_le(logic [31:0] w);
    file_bytes.push_back(w[7:0]);
    file_bytes.push_back(w[15:8]);
    file_bytes.push_back(w[23:16]);
    file_bytes.push_back(w[31:24]);
  endfunction

  function automatic void put_half_le(logic [15:0] h);
    file_bytes.push_back(h[7:0]);
    file_bytes.push_back(h[15:8]);
  endfunction

  function automatic logic [31:0] maybe_spoil(logic [31:0] tag);
    return ($urandom_range(99) < 6) ? tag ^ (32'd1 << $urandom_range(31)) : tag;
  endfunction

  function automatic logic [7:0] sample_byte();
    int pick;
    pick = $urandom_range(99);
    if (pick < 15) return 8'h00;
    if (pick < 30) return 8'hFF;
    if (pick < 40) return 8'h80;
    if (pick < 50) return 8'h7F;
    return 8'($urandom);
  endfunction

  function automatic void put_filler_chunk();
    logic [31:0] tag;
    logic [31:0] len;
    tag = $urandom;
    if (tag == TAG_FMT || tag == TAG_DATA) tag[0] = ~tag[0];
    // Now and then the declared length runs past the end of the file.
    if ($urandom_range(99) < 8) len = $urandom;
    else len = $urandom_range(0, 7);
    put_word_be(tag);
    put_word_le(len);
    repeat ((len > 7) ? $urandom_range(0, 5) : len + len[0])
      file_bytes.push_back(8'($urandom));
  endfunction

  function automatic void put_fmt_chunk(bit clean);
    logic [31:0] len;
    logic [31:0] rate;
    logic [15:0] chans;
    int pick;
    pick = $urandom_range(99);
    if (clean || pick < 70) len = 16;
    else if (pick < 85) len = $urandom_range(17, 23);
    else len = $urandom_range(0, 15);
    pick = $urandom_range(99);
    if (clean || pick < 80) chans = 16'd1;
    else if (pick < 87) chans = 16'd2;
    else if (pick < 93) chans = 16'd0;
    else chans = 16'($urandom);
    pick = $urandom_range(99);
    if (clean) rate = 32'd44100;
    else if (pick < 30) rate = 32'd8000;
    else if (pick < 55) rate = 32'd48000;
    else if (pick < 65) rate = 32'd1;
    else if (pick < 80) rate = $urandom;
    else if (pick < 90) rate = 32'hFFFF_FFFF;
    else rate = 32'd0;
    put_word_be(TAG_FMT);
    put_word_le(len);
    if (len < 16) begin
      repeat (len + len[0]) file_bytes.push_back(8'($urandom));
    end else begin
      put_half_le(16'd1);
      put_half_le(chans);
      put_word_le(rate);
      put_word_le(rate << 1);
      put_half_le(16'd2);
      put_half_le(16'd16);
      repeat (len - 16 + len[0]) file_bytes.push_back(8'($urandom));
    end
  endfunction

  function automatic void put_data_chunk(bit clean);
    logic [31:0] len;
    int body;
    if (clean) len = 64;
    else if ($urandom_range(99) < 10) len = 32'h8000_0000 | $urandom;
    else len = $urandom_range(0, 21);
    put_word_be(TAG_DATA);
    put_word_le(len);
    body = (len > 64) ? $urandom_range(0, 9) : int'(len);
    repeat (body) file_bytes.push_back(sample_byte());
  endfunction

  // A clean file always parses to the end and carries a long data chunk.
  function automatic void build_file(bit clean);
    int cut;
    file_bytes.delete();
    if (!clean && $urandom_range(99) < 8) begin
      if ($urandom_range(1) == 1) put_word_be(TAG_RIFF);
      repeat ($urandom_range(1, 12)) file_bytes.push_back(8'($urandom));
      return;
    end
    put_word_be(clean ? TAG_RIFF : maybe_spoil(TAG_RIFF));
    put_word_le($urandom);
    put_word_be(clean ? TAG_WAVE : maybe_spoil(TAG_WAVE));
    if (!clean && $urandom_range(99) < 30) put_filler_chunk();
    if (clean || $urandom_range(99) < 88) put_fmt_chunk(clean);
    if (!clean && $urandom_range(99) < 25) put_filler_chunk();
    if (!clean && $urandom_range(99) < 10) put_fmt_chunk(1'b0);
    if (clean || $urandom_range(99) < 92) put_data_chunk(clean);
    if (!clean && $urandom_range(99) < 40)
      repeat ($urandom_range(1, 3)) file_bytes.push_back(8'($urandom));
    if (!clean && $urandom_range(99) < 25) begin
      cut = $urandom_range(0, file_bytes.size() - 1);
      while (file_bytes.size() > cut) void'(file_bytes.pop_back());
    end
  endfunction

  task automatic run_phase(int send_pct, int recv_pct, int goal, bit with_hold);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    if (with_hold) begin
      // The receiver holds off while a long data chunk keeps arriving.
      hold_request <= hold_request + 1;
      build_file(1'b1);
      send_file();
    end
    while (accepted_items < goal) begin
      build_file(1'b0);
      send_file();
    end
    wait_results_drained(50000);
  endtask

  initial begin
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.op        <= OP_BYTE;
    in_ch.data_byte <= 8'h00;
    send_idle_pct = 29;
    recv_idle_pct = 67;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // End of file before any byte, then inside the RIFF tag.
    file_bytes.delete();
    send_file();
    put_word_be(TAG_RIFF);
    void'(file_bytes.pop_back());
    send_file();
    // A wrong last tag byte, then a byte that must be ignored.
    file_bytes.delete();
    put_word_be(TAG_RIFF);
    file_bytes[3] = 8'h58;
    file_bytes.push_back(8'hFF);
    send_file();
    // End of file inside the RIFF size field.
    file_bytes.delete();
    put_word_be(TAG_RIFF);
    file_bytes.push_back(8'h00);
    file_bytes.push_back(8'hFF);
    send_file();
    wait_results_drained(50000);

    run_phase(29, 67, 450, 1'b0);
    run_phase(67, 29, 900, 1'b0);
    run_phase(0, 0, 1350, 1'b1);

    if (tracker.mismatch_count == 0 && tracker.awaited_results.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
